// ----- rtl/ve3d_pkg.sv -----
// shared constants, types and helper functions of the 3x3x3 erosion block
package ve3d_pkg;

	localparam int unsigned MAX_X = 256;
	localparam int unsigned MAX_Y = 256;
	localparam int unsigned MAX_Z = 4096;

	localparam int CFG_X_W = 9;
	localparam int CFG_Y_W = 9;
	localparam int CFG_Z_W = 13;
	localparam int CFG_W   = 13;
	localparam int IDX_W   = 2;
	localparam int VOX_W   = 8;

	localparam int XC_W  = (MAX_X > 1) ? $clog2(MAX_X) : 1;
	localparam int YC_W  = (MAX_Y > 1) ? $clog2(MAX_Y) : 1;
	localparam int ZC_W  = (MAX_Z > 1) ? $clog2(MAX_Z) : 1;
	localparam int SZX_W = $clog2(MAX_X + 1);
	localparam int SZY_W = $clog2(MAX_Y + 1);
	localparam int SZZ_W = $clog2(MAX_Z + 1);
	localparam int PW    = $clog2(MAX_X * MAX_Y + 1);
	localparam int PL_W  = $clog2(MAX_X * MAX_Y);
	localparam int CNT_W = $clog2(MAX_X * MAX_Y + MAX_X + 2);

	typedef enum logic [IDX_W-1:0] {
		REG_SIZE_X = 2'd0,
		REG_SIZE_Y = 2'd1,
		REG_SIZE_Z = 2'd2
	} ve3d_reg_t;

	function automatic int unsigned eff_size(input int unsigned v, input int unsigned maxv);
		if (v == 0)
			return 1;
		else if (v > maxv)
			return maxv;
		else
			return v;
	endfunction

	localparam int unsigned RST_SX = eff_size(256, MAX_X);
	localparam int unsigned RST_SY = eff_size(256, MAX_Y);
	localparam int unsigned RST_SZ = eff_size(1, MAX_Z);

	typedef struct packed {
		logic xlo;
		logic xhi;
		logic ylo;
		logic yhi;
		logic zlo;
		logic zhi;
	} ve3d_nb_t;

	typedef struct packed {
		logic     shift;
		logic     clr;
		logic     emit;
		logic     last;
		ve3d_nb_t nb;
	} ve3d_step_t;

	typedef struct packed {
		logic [XC_W-1:0] line_len;
		logic [PL_W-1:0] plane_len;
	} ve3d_len_t;

endpackage

// ----- rtl/ve3d_in_if.sv -----
// voxel input channel
interface ve3d_in_if;
	import ve3d_pkg::*;
	logic             valid;
	logic             ready;
	logic             command;
	logic [VOX_W-1:0] voxel;
	modport source(output valid, command, voxel, input ready);
	modport sink(input valid, command, voxel, output ready);
endinterface

// ----- rtl/ve3d_out_if.sv -----
// eroded voxel output channel
interface ve3d_out_if;
	import ve3d_pkg::*;
	logic             valid;
	logic             ready;
	logic [VOX_W-1:0] value;
	logic             last;
	modport source(output valid, value, last, input ready);
	modport sink(input valid, value, last, output ready);
endinterface

// ----- rtl/ve3d_cfg_if.sv -----
// configuration write channel
interface ve3d_cfg_if;
	import ve3d_pkg::*;
	logic             valid;
	logic             ready;
	logic [IDX_W-1:0] index;
	logic [CFG_W-1:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ----- rtl/ve3d_delay.sv -----
// programmable length delay line built on a single port memory
module ve3d_delay #(
	parameter int DEPTH = 256,
	parameter int W     = 8
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     clr,
	input  logic                     shift,
	input  logic [$clog2(DEPTH)-1:0] len,
	input  logic [W-1:0]             din,
	output logic [W-1:0]             dout
);
	localparam int AW = $clog2(DEPTH);

	logic [W-1:0]  mem [DEPTH];
	logic [AW-1:0] ptr_q;
	logic [W-1:0]  rd_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			mem[ptr_q] <= din;
			rd_q       <= (len == '0) ? din : mem[ptr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
		end else if (clr) begin
			ptr_q <= '0;
		end else if (shift) begin
			if (len == '0 || ptr_q >= len - AW'(1))
				ptr_q <= '0;
			else
				ptr_q <= ptr_q + AW'(1);
		end
	end

	assign dout = rd_q;
endmodule

// ----- rtl/ve3d_seq.sv -----
// size registers, input and output raster counters, stream sequencing
module ve3d_seq (
	input  logic                 clk,
	input  logic                 arst_n,
	ve3d_cfg_if.sink             cfg,
	input  logic                 in_valid,
	input  logic                 command,
	input  logic                 s1_free,
	output logic                 in_ready,
	output ve3d_pkg::ve3d_step_t step,
	output ve3d_pkg::ve3d_len_t  lens
);
	import ve3d_pkg::*;

	logic [SZX_W-1:0] sx_q;
	logic [SZY_W-1:0] sy_q;
	logic [SZZ_W-1:0] sz_q;
	logic [PW-1:0]    plane_q;
	logic [XC_W-1:0]  in_x_q, out_x_q, in_x_nx, out_x_nx;
	logic [YC_W-1:0]  in_y_q, out_y_q, in_y_nx, out_y_nx;
	logic [ZC_W-1:0]  in_z_q, out_z_q, in_z_nx, out_z_nx;
	logic [CNT_W-1:0] pending_q, ahead_q, lag;
	logic [SZX_W-1:0] nsx;
	logic [SZY_W-1:0] nsy;
	logic [SZZ_W-1:0] nsz;
	logic             cfg_wr, complete, dummy, acc, voxel_wr, drain;

	assign cfg.ready = 1'b1;
	assign cfg_wr    = cfg.valid && (cfg.index inside {REG_SIZE_X, REG_SIZE_Y, REG_SIZE_Z});
	assign nsx = SZX_W'(eff_size(32'(cfg.data[CFG_X_W-1:0]), MAX_X));
	assign nsy = SZY_W'(eff_size(32'(cfg.data[CFG_Y_W-1:0]), MAX_Y));
	assign nsz = SZZ_W'(eff_size(32'(cfg.data[CFG_Z_W-1:0]), MAX_Z));

	always_comb begin
		lag      = CNT_W'(plane_q) + CNT_W'(sx_q) + CNT_W'(1);
		complete = (pending_q != '0) && (in_x_q == '0) && (in_y_q == '0) && (in_z_q == '0);
		dummy    = complete && (ahead_q != lag);
		in_ready = s1_free && !dummy;
		acc      = in_valid && in_ready;
		voxel_wr = acc && !command && !complete;
		drain    = acc && complete;

		step.shift = voxel_wr || drain || (dummy && s1_free);
		step.clr   = cfg_wr;
		step.emit  = drain || (voxel_wr && (ahead_q == lag));
		step.last  = (SZX_W'(out_x_q) == sx_q - SZX_W'(1)) &&
			(SZY_W'(out_y_q) == sy_q - SZY_W'(1)) &&
			(SZZ_W'(out_z_q) == sz_q - SZZ_W'(1));
		step.nb.xlo = out_x_q != '0;
		step.nb.xhi = SZX_W'(out_x_q) != sx_q - SZX_W'(1);
		step.nb.ylo = out_y_q != '0;
		step.nb.yhi = SZY_W'(out_y_q) != sy_q - SZY_W'(1);
		step.nb.zlo = out_z_q != '0;
		step.nb.zhi = SZZ_W'(out_z_q) != sz_q - SZZ_W'(1);

		lens.line_len  = XC_W'(sx_q - SZX_W'(1));
		lens.plane_len = PL_W'(plane_q - PW'(1));
	end

	// raster advance, x fastest
	always_comb begin
		in_x_nx = in_x_q + XC_W'(1);
		in_y_nx = in_y_q;
		in_z_nx = in_z_q;
		if (SZX_W'(in_x_q) + SZX_W'(1) == sx_q) begin
			in_x_nx = '0;
			in_y_nx = in_y_q + YC_W'(1);
			if (SZY_W'(in_y_q) + SZY_W'(1) == sy_q) begin
				in_y_nx = '0;
				in_z_nx = in_z_q + ZC_W'(1);
				if (SZZ_W'(in_z_q) + SZZ_W'(1) == sz_q)
					in_z_nx = '0;
			end
		end
		out_x_nx = out_x_q + XC_W'(1);
		out_y_nx = out_y_q;
		out_z_nx = out_z_q;
		if (SZX_W'(out_x_q) + SZX_W'(1) == sx_q) begin
			out_x_nx = '0;
			out_y_nx = out_y_q + YC_W'(1);
			if (SZY_W'(out_y_q) + SZY_W'(1) == sy_q) begin
				out_y_nx = '0;
				out_z_nx = out_z_q + ZC_W'(1);
				if (SZZ_W'(out_z_q) + SZZ_W'(1) == sz_q)
					out_z_nx = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sx_q      <= SZX_W'(RST_SX);
			sy_q      <= SZY_W'(RST_SY);
			sz_q      <= SZZ_W'(RST_SZ);
			plane_q   <= PW'(RST_SX * RST_SY);
			in_x_q    <= '0;
			in_y_q    <= '0;
			in_z_q    <= '0;
			out_x_q   <= '0;
			out_y_q   <= '0;
			out_z_q   <= '0;
			pending_q <= '0;
			ahead_q   <= '0;
		end else if (cfg_wr) begin
			case (cfg.index)
				REG_SIZE_X: begin
					sx_q    <= nsx;
					plane_q <= PW'(nsx * sy_q);
				end
				REG_SIZE_Y: begin
					sy_q    <= nsy;
					plane_q <= PW'(sx_q * nsy);
				end
				REG_SIZE_Z: sz_q <= nsz;
				default: ;
			endcase
			if (cfg.index == REG_SIZE_X || cfg.index == REG_SIZE_Y ||
				cfg.index == REG_SIZE_Z) begin
				in_x_q    <= '0;
				in_y_q    <= '0;
				in_z_q    <= '0;
				out_x_q   <= '0;
				out_y_q   <= '0;
				out_z_q   <= '0;
				pending_q <= '0;
				ahead_q   <= '0;
			end
		end else begin
			if (voxel_wr) begin
				in_x_q <= in_x_nx;
				in_y_q <= in_y_nx;
				in_z_q <= in_z_nx;
				if (!step.emit) begin
					pending_q <= pending_q + CNT_W'(1);
					ahead_q   <= ahead_q + CNT_W'(1);
				end
			end
			// padding beats line up the window before draining a short volume
			if (dummy && s1_free)
				ahead_q <= ahead_q + CNT_W'(1);
			if (step.emit) begin
				out_x_q <= out_x_nx;
				out_y_q <= out_y_nx;
				out_z_q <= out_z_nx;
			end
			if (drain) begin
				pending_q <= pending_q - CNT_W'(1);
				if (pending_q == CNT_W'(1))
					ahead_q <= '0;
			end
		end
	end
endmodule

// ----- rtl/ve3d_window.sv -----
// plane and line buffers, 3x3x3 tap window and the erosion decision
module ve3d_window (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ve3d_pkg::ve3d_step_t          step,
	input  ve3d_pkg::ve3d_len_t           lens,
	input  logic [ve3d_pkg::VOX_W-1:0]    voxel,
	input  logic                          adv,
	output logic                          res_valid,
	output logic [ve3d_pkg::VOX_W-1:0]    res_value,
	output logic                          res_last
);
	import ve3d_pkg::*;

	logic [VOX_W-1:0] h00_q;
	logic [VOX_W-1:0] head [3][3];
	logic [VOX_W-1:0] tap1_q [3][3];
	logic [VOX_W-1:0] tap2_q [3][3];
	logic             valid_s1;
	logic             last_s1;
	ve3d_nb_t         nb_s1;
	logic             ok;

	assign head[0][0] = h00_q;

	ve3d_delay #(.DEPTH(MAX_X * MAX_Y), .W(VOX_W)) u_plane1 (
		.clk(clk), .arst_n(arst_n), .clr(step.clr), .shift(step.shift),
		.len(lens.plane_len), .din(head[0][0]), .dout(head[1][0])
	);

	ve3d_delay #(.DEPTH(MAX_X * MAX_Y), .W(VOX_W)) u_plane2 (
		.clk(clk), .arst_n(arst_n), .clr(step.clr), .shift(step.shift),
		.len(lens.plane_len), .din(head[1][0]), .dout(head[2][0])
	);

	for (genvar a = 0; a < 3; a++) begin : g_pl
		for (genvar b = 1; b < 3; b++) begin : g_ln
			ve3d_delay #(.DEPTH(MAX_X), .W(VOX_W)) u_line (
				.clk(clk), .arst_n(arst_n), .clr(step.clr), .shift(step.shift),
				.len(lens.line_len), .din(head[a][b-1]), .dout(head[a][b])
			);
		end
	end

	always_ff @(posedge clk) begin
		if (step.shift) begin
			h00_q <= voxel;
			for (int a = 0; a < 3; a++) begin
				for (int b = 0; b < 3; b++) begin
					tap1_q[a][b] <= head[a][b];
					tap2_q[a][b] <= tap1_q[a][b];
				end
			end
			nb_s1   <= step.nb;
			last_s1 <= step.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (step.shift) begin
			valid_s1 <= step.emit;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	// tap index 0 is the newest voxel, so it is the +1 neighbor on each axis
	always_comb begin
		ok = 1'b1;
		for (int a = 0; a < 3; a++) begin
			for (int b = 0; b < 3; b++) begin
				if (!((a == 0 && !nb_s1.zhi) || (a == 2 && !nb_s1.zlo) ||
					(b == 0 && !nb_s1.yhi) || (b == 2 && !nb_s1.ylo))) begin
					if (nb_s1.xhi && head[a][b] == '0)
						ok = 1'b0;
					if (tap1_q[a][b] == '0)
						ok = 1'b0;
					if (nb_s1.xlo && tap2_q[a][b] == '0)
						ok = 1'b0;
				end
			end
		end
	end

	assign res_valid = valid_s1;
	assign res_value = ok ? tap1_q[1][1] : '0;
	assign res_last  = last_s1;
endmodule

// ----- rtl/volume_erosion_3x3x3_core.sv -----
// top level of the streaming 3x3x3 volume erosion
//
//  channel   role    beat contents
//  voxels    sink    command, voxel
//  results   source  value, last
//  cfg       sink    index, data (size_x, size_y, size_z)
//
// one beat per cycle in both directions while results are taken and no padding runs; result trails its voxel by
// size_x*size_y + size_x + 1 input beats, held in two plane and six line buffers
// when a volume holds fewer voxels than that lag, the drain waits for internal
// padding beats to make up the difference before flush beats are taken
// arst_n clears counters and sizes (256, 256, 1); buffer contents are not cleared
// a stalled result sits in the output register while the next beat is taken
module volume_erosion_3x3x3_core (
	input  logic      clk,
	input  logic      arst_n,
	ve3d_in_if.sink   voxels,
	ve3d_out_if.source results,
	ve3d_cfg_if.sink  cfg
);
	import ve3d_pkg::*;

	ve3d_step_t       step;
	ve3d_len_t        lens;
	logic             adv, s1_free;
	logic             res_valid, res_last;
	logic [VOX_W-1:0] res_value;
	logic             out_valid_q, out_last_q;
	logic [VOX_W-1:0] out_value_q;

	assign adv     = !out_valid_q || results.ready;
	assign s1_free = !res_valid || adv;

	ve3d_seq u_seq (
		.clk(clk), .arst_n(arst_n), .cfg(cfg),
		.in_valid(voxels.valid), .command(voxels.command), .s1_free(s1_free),
		.in_ready(voxels.ready), .step(step), .lens(lens)
	);

	ve3d_window u_window (
		.clk(clk), .arst_n(arst_n), .step(step), .lens(lens),
		.voxel(voxels.voxel), .adv(adv),
		.res_valid(res_valid), .res_value(res_value), .res_last(res_last)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res_valid) begin
			out_value_q <= res_value;
			out_last_q  <= res_last;
		end
	end

	assign results.valid = out_valid_q;
	assign results.value = out_value_q;
	assign results.last  = out_last_q;
endmodule
